// ===== rtl/core/jpeg_exif_header_parser_core_macros.svh =====
// assertion helpers for the jpeg parser
`ifndef JPEG_EXIF_HEADER_PARSER_CORE_MACROS_SVH
`define JPEG_EXIF_HEADER_PARSER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define JEHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define JEHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/jehp_pkg.sv =====
`default_nettype none
package jehp_pkg;

    localparam int SEGMENT_BYTES = 65536;
    localparam int SEG_AW = $clog2(SEGMENT_BYTES);
    localparam int MAX_IFDS = 2;
    localparam int IFD_W = $clog2(MAX_IFDS + 1);

    localparam logic [15:0] MARKER_SOS = 16'hffda;
    localparam logic [15:0] MARKER_APP1 = 16'hffe1;
    localparam logic [15:0] MARKER_SOF0 = 16'hffc0;
    localparam logic [15:0] MARKER_SOF3 = 16'hffc3;
    localparam logic [7:0] SOI_FIRST = 8'hff;
    localparam logic [7:0] SOI_SECOND = 8'hd8;
    localparam logic [15:0] TIFF_MAGIC = 16'h002a;
    localparam logic [15:0] BOM_BIG = 16'h4d4d;
    localparam logic [15:0] BOM_LITTLE = 16'h4949;
    localparam logic [15:0] TAG_THUMB_OFF = 16'h0201;
    localparam logic [15:0] TAG_THUMB_SIZE = 16'h0202;
    localparam logic [15:0] TAG_ORIENT = 16'h0112;
    localparam logic [47:0] EXIF_MAGIC = 48'h457869660000;

    localparam logic [15:0] TYPE_U8 = 16'd1;
    localparam logic [15:0] TYPE_ASCII = 16'd2;
    localparam logic [15:0] TYPE_U16 = 16'd3;
    localparam logic [15:0] TYPE_U32 = 16'd4;
    localparam logic [15:0] TYPE_S8 = 16'd6;
    localparam logic [15:0] TYPE_S16 = 16'd8;

    localparam logic [1:0] REG_WANT_DIM = 2'd0;
    localparam logic [1:0] REG_WANT_EXIF = 2'd1;
    localparam logic [1:0] REG_WANT_THUMB = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_SOI = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [1:0] {KIND_SKIP, KIND_SOF, KIND_APP1} seg_kind_t;

    typedef enum logic [3:0] {
        PH_SOI0, PH_SOI1, PH_M0, PH_M1, PH_L0, PH_L1, PH_BODY, PH_PARSE, PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        WK_IDLE, WK_READ, WK_SOF, WK_MAGIC, WK_HDR, WK_CHK, WK_CNT, WK_ELOOP,
        WK_ENT, WK_NEXT, WK_FIN, WK_DONE
    } walk_state_t;

    typedef struct packed {
        logic done;
        logic err;
    } walk_res_t;

    function automatic logic [15:0] rd16(input logic [7:0] a, input logic [7:0] b,
                                         input logic be);
        rd16 = be ? {a, b} : {b, a};
    endfunction

    function automatic logic [31:0] rd32(input logic [31:0] bytes_in, input logic be);
        rd32 = be ? bytes_in : {bytes_in[7:0], bytes_in[15:8], bytes_in[23:16],
                                bytes_in[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jehp_ram.sv =====
`default_nettype none
module jehp_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/jehp_walker.sv =====
`default_nettype none
module jehp_walker import jehp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clr,
    input  wire logic              start,
    input  wire seg_kind_t         kind,
    input  wire logic [16:0]       seg_len,
    input  wire logic              want_thumb,
    output logic [SEG_AW-1:0]      rd_addr,
    input  wire logic [7:0]        rd_data,
    output walk_res_t              res,
    output logic signed [16:0]     width_out,
    output logic signed [16:0]     height_out,
    output logic [31:0]            orient_out,
    output logic                   thumb_valid_out,
    output logic [15:0]            thumb_off_out,
    output logic [15:0]            thumb_size_out
);

    walk_state_t state_reg, state_next, ret_reg, ret_next;
    logic [16:0] ptr_reg, ptr_next;
    logic [3:0] left_reg, left_next;
    logic pend_reg, pend_next;
    logic [95:0] buf_reg, buf_next;
    logic err_reg, err_next;
    logic be_reg, be_next;
    logic [31:0] ifd_reg, ifd_next;
    logic [IFD_W-1:0] idx_reg, idx_next;
    logic [15:0] ent_reg, ent_next;
    logic [16:0] n_reg, n_next;
    logic [16:0] tl_reg, tl_next;
    logic [31:0] off_reg, off_next, size_reg, size_next;
    logic off_seen_reg, off_seen_next, size_seen_reg, size_seen_next;
    logic signed [16:0] w_reg, w_next, h_reg, h_next;
    logic [31:0] or_reg, or_next;
    logic tv_reg, tv_next;
    logic [15:0] to_reg, to_next, ts_reg, ts_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WK_IDLE;
            pend_reg <= 1'b0;
            w_reg <= -17'sd1;
            h_reg <= -17'sd1;
            or_reg <= '0;
            tv_reg <= 1'b0;
            to_reg <= '0;
            ts_reg <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg <= pend_next;
            w_reg <= w_next;
            h_reg <= h_next;
            or_reg <= or_next;
            tv_reg <= tv_next;
            to_reg <= to_next;
            ts_reg <= ts_next;
        end
        ret_reg <= ret_next;
        ptr_reg <= ptr_next;
        left_reg <= left_next;
        buf_reg <= buf_next;
        err_reg <= err_next;
        be_reg <= be_next;
        ifd_reg <= ifd_next;
        idx_reg <= idx_next;
        ent_reg <= ent_next;
        n_reg <= n_next;
        tl_reg <= tl_next;
        off_reg <= off_next;
        size_reg <= size_next;
        off_seen_reg <= off_seen_next;
        size_seen_reg <= size_seen_next;
    end

    always_comb begin
        logic [15:0] ety, etag, cnt;
        logic [31:0] val;
        logic [33:0] lim;
        state_next = state_reg;
        ret_next = ret_reg;
        ptr_next = ptr_reg;
        left_next = left_reg;
        pend_next = pend_reg;
        buf_next = buf_reg;
        err_next = err_reg;
        be_next = be_reg;
        ifd_next = ifd_reg;
        idx_next = idx_reg;
        ent_next = ent_reg;
        n_next = n_reg;
        tl_next = tl_reg;
        off_next = off_reg;
        size_next = size_reg;
        off_seen_next = off_seen_reg;
        size_seen_next = size_seen_reg;
        w_next = w_reg;
        h_next = h_reg;
        or_next = or_reg;
        tv_next = tv_reg;
        to_next = to_reg;
        ts_next = ts_reg;
        res = '0;
        ety = rd16(buf_reg[79:72], buf_reg[71:64], be_reg);
        etag = rd16(buf_reg[95:88], buf_reg[87:80], be_reg);
        cnt = rd16(buf_reg[15:8], buf_reg[7:0], be_reg);
        lim = {2'b00, ifd_reg} + 34'd6 + {16'd0, cnt, 2'b00} + {15'd0, cnt, 3'b000};
        val = '0;
        case (ety)
            TYPE_U8: val = {24'd0, buf_reg[31:24]};
            TYPE_ASCII, TYPE_U32: val = rd32(buf_reg[31:0], be_reg);
            TYPE_U16: val = {16'd0, rd16(buf_reg[31:24], buf_reg[23:16], be_reg)};
            TYPE_S8: val = {{24{buf_reg[31]}}, buf_reg[31:24]};
            TYPE_S16: begin
                val = {16'd0, rd16(buf_reg[31:24], buf_reg[23:16], be_reg)};
                val[31:16] = {16{val[15]}};
            end
            default: val = '0;
        endcase

        case (state_reg)
            WK_IDLE: begin
                if (start) begin
                    n_next = seg_len;
                    err_next = 1'b0;
                    off_seen_next = 1'b0;
                    size_seen_next = 1'b0;
                    pend_next = 1'b0;
                    state_next = WK_READ;
                    if (kind == KIND_SOF) begin
                        ptr_next = 17'd1;
                        left_next = 4'd4;
                        ret_next = WK_SOF;
                        if (seg_len < 17'd5) begin
                            err_next = 1'b1;
                            state_next = WK_DONE;
                        end
                    end else begin
                        ptr_next = 17'd0;
                        left_next = 4'd6;
                        ret_next = WK_MAGIC;
                        if (seg_len < 17'd6) begin
                            state_next = WK_DONE;
                        end
                    end
                end
            end
            WK_READ: begin
                if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    buf_next = {buf_reg[87:0], rd_data};
                    ptr_next = ptr_reg + 17'd1;
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        state_next = ret_reg;
                    end
                end
            end
            WK_SOF: begin
                h_next = {1'b0, buf_reg[31:16]};
                w_next = {1'b0, buf_reg[15:0]};
                state_next = WK_DONE;
            end
            WK_MAGIC: begin
                tl_next = n_reg - 17'd6;
                if (buf_reg[47:0] != EXIF_MAGIC) begin
                    state_next = WK_DONE;
                end else if (n_reg < 17'd14) begin
                    err_next = 1'b1;
                    state_next = WK_DONE;
                end else begin
                    ptr_next = 17'd6;
                    left_next = 4'd8;
                    ret_next = WK_HDR;
                    state_next = WK_READ;
                end
            end
            WK_HDR: begin
                state_next = WK_CHK;
                idx_next = '0;
                if (buf_reg[63:48] == BOM_BIG) begin
                    be_next = 1'b1;
                end else if (buf_reg[63:48] == BOM_LITTLE) begin
                    be_next = 1'b0;
                end else begin
                    err_next = 1'b1;
                    state_next = WK_DONE;
                end
                if (rd16(buf_reg[47:40], buf_reg[39:32], be_next) != TIFF_MAGIC) begin
                    err_next = 1'b1;
                    state_next = WK_DONE;
                end
                ifd_next = rd32(buf_reg[31:0], be_next);
            end
            WK_CHK: begin
                if (ifd_reg == 32'd0 || idx_reg == IFD_W'(MAX_IFDS)) begin
                    state_next = WK_FIN;
                end else if ({2'b00, ifd_reg} + 34'd2 > {17'd0, tl_reg}) begin
                    err_next = 1'b1;
                    state_next = WK_DONE;
                end else begin
                    ptr_next = ifd_reg[16:0] + 17'd6;
                    left_next = 4'd2;
                    ret_next = WK_CNT;
                    state_next = WK_READ;
                end
            end
            WK_CNT: begin
                ent_next = cnt;
                // table plus next-link must lie inside the tiff data
                if (lim > {17'd0, tl_reg}) begin
                    err_next = 1'b1;
                    state_next = WK_DONE;
                end else begin
                    state_next = WK_ELOOP;
                end
            end
            WK_ELOOP: begin
                state_next = WK_READ;
                if (ent_reg == 16'd0) begin
                    left_next = 4'd4;
                    ret_next = WK_NEXT;
                end else begin
                    left_next = 4'd12;
                    ret_next = WK_ENT;
                end
            end
            WK_ENT: begin
                ent_next = ent_reg - 16'd1;
                state_next = WK_ELOOP;
                if (idx_reg == IFD_W'(1) && etag == TAG_THUMB_OFF) begin
                    off_next = val;
                    off_seen_next = 1'b1;
                end else if (idx_reg == IFD_W'(1) && etag == TAG_THUMB_SIZE) begin
                    size_next = val;
                    size_seen_next = 1'b1;
                end else if (idx_reg == '0 && etag == TAG_ORIENT) begin
                    or_next = val;
                end
            end
            WK_NEXT: begin
                ifd_next = rd32(buf_reg[31:0], be_reg);
                idx_next = idx_reg + IFD_W'(1);
                state_next = WK_CHK;
            end
            WK_FIN: begin
                if (want_thumb && off_seen_reg && size_seen_reg &&
                    ({1'b0, off_reg} + {1'b0, size_reg} <= {16'd0, tl_reg})) begin
                    tv_next = 1'b1;
                    to_next = off_reg[15:0];
                    ts_next = size_reg[15:0];
                end
                state_next = WK_DONE;
            end
            WK_DONE: begin
                res.done = 1'b1;
                res.err = err_reg;
                state_next = WK_IDLE;
            end
            default: state_next = WK_IDLE;
        endcase

        if (clr) begin
            w_next = -17'sd1;
            h_next = -17'sd1;
            or_next = '0;
            tv_next = 1'b0;
            to_next = '0;
            ts_next = '0;
        end
    end

    assign rd_addr = ptr_reg[SEG_AW-1:0];
    assign width_out = w_reg;
    assign height_out = h_reg;
    assign orient_out = or_reg;
    assign thumb_valid_out = tv_reg;
    assign thumb_off_out = to_reg;
    assign thumb_size_out = ts_reg;

endmodule
`default_nettype wire

// ===== rtl/core/jpeg_exif_header_parser_core.sv =====
`default_nettype none
// one byte per cycle through the marker walk while no result waits for m_ready;
// sof and app1 bodies are stored as they arrive and walked from the segment ram
// after the last body byte, one ram byte at a time, with input stalled meanwhile
// a result leaves from an output register in the cycle after the deciding byte or walk
// synchronous active-low reset; config regs reset to dimensions=1, exif=1, thumbnail=0
`include "jpeg_exif_header_parser_core_macros.svh"
module jpeg_exif_header_parser_core import jehp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [0:0]         cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_end_of_file,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [16:0]      m_image_width,
    output logic signed [16:0]      m_image_height,
    output logic signed [31:0]      m_orientation,
    output logic                    m_thumb_valid,
    output logic [15:0]             m_thumb_offset,
    output logic [15:0]             m_thumb_size
);

    phase_t phase_reg, phase_next;
    seg_kind_t kind_reg, kind_next;
    logic want_dim_reg, want_exif_reg, want_thumb_reg;
    logic [15:0] marker_reg, marker_next, len_reg, len_next, cnt_reg, cnt_next;
    logic eofp_reg, eofp_next;
    logic m_valid_reg;
    logic [1:0] st_reg;
    logic signed [16:0] w_o_reg, h_o_reg;
    logic [31:0] or_o_reg;
    logic tv_o_reg;
    logic [15:0] to_o_reg, ts_o_reg;

    logic load_out, clr, wr_en, w_start;
    logic [1:0] st_new;
    logic [16:0] seg_n;
    logic [SEG_AW-1:0] rd_addr;
    logic [7:0] rd_data;
    walk_res_t w_res;
    logic signed [16:0] w_w, w_h;
    logic [31:0] w_or;
    logic w_tv;
    logic [15:0] w_to, w_ts;

    wire xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_dim_reg <= 1'b1;
            want_exif_reg <= 1'b1;
            want_thumb_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WANT_DIM: want_dim_reg <= cfg_wr_data[0];
                REG_WANT_EXIF: want_exif_reg <= cfg_wr_data[0];
                REG_WANT_THUMB: want_thumb_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SOI0;
            kind_reg <= KIND_SKIP;
            m_valid_reg <= 1'b0;
            eofp_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            eofp_reg <= eofp_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        marker_reg <= marker_next;
        len_reg <= len_next;
        cnt_reg <= cnt_next;
        if (load_out) begin
            st_reg <= st_new;
            w_o_reg <= w_w;
            h_o_reg <= w_h;
            or_o_reg <= w_or;
            tv_o_reg <= w_tv;
            to_o_reg <= w_to;
            ts_o_reg <= w_ts;
        end
    end

    // after a result only end of file matters, so those bytes need no free slot
    assign s_ready = (phase_reg != PH_PARSE) &&
                     (phase_reg == PH_DONE || !m_valid_reg || m_ready);

    always_comb begin
        logic [15:0] full_len;
        logic body_end;
        phase_next = phase_reg;
        kind_next = kind_reg;
        marker_next = marker_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        eofp_next = eofp_reg;
        load_out = 1'b0;
        st_new = ST_OK;
        clr = 1'b0;
        wr_en = 1'b0;
        w_start = 1'b0;
        body_end = 1'b0;
        full_len = {len_reg[15:8], s_data_byte} - 16'd2;
        if (xfer) begin
            case (phase_reg)
                PH_SOI0: begin
                    if (s_data_byte != SOI_FIRST || s_end_of_file) begin
                        load_out = 1'b1;
                        st_new = ST_NO_SOI;
                    end else begin
                        phase_next = PH_SOI1;
                    end
                end
                PH_SOI1: begin
                    if (s_data_byte != SOI_SECOND) begin
                        load_out = 1'b1;
                        st_new = ST_NO_SOI;
                    end else begin
                        phase_next = PH_M0;
                    end
                end
                PH_M0: begin
                    marker_next = {s_data_byte, 8'd0};
                    phase_next = PH_M1;
                end
                PH_M1: begin
                    marker_next = {marker_reg[15:8], s_data_byte};
                    phase_next = PH_L0;
                end
                PH_L0: begin
                    len_next = {s_data_byte, 8'd0};
                    phase_next = PH_L1;
                end
                PH_L1: begin
                    if (marker_reg == MARKER_SOS) begin
                        load_out = 1'b1;
                        st_new = ST_OK;
                    end else begin
                        len_next = full_len;
                        cnt_next = '0;
                        if (marker_reg >= MARKER_SOF0 && marker_reg <= MARKER_SOF3 &&
                            want_dim_reg) begin
                            kind_next = KIND_SOF;
                        end else if (marker_reg == MARKER_APP1 &&
                                     (want_exif_reg || want_thumb_reg)) begin
                            kind_next = KIND_APP1;
                        end else begin
                            kind_next = KIND_SKIP;
                        end
                        if (full_len == 16'd0) begin
                            body_end = 1'b1;
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    wr_en = (kind_reg != KIND_SKIP) &&
                            ({1'b0, cnt_reg} < 17'(SEGMENT_BYTES));
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_next == len_reg) begin
                        body_end = 1'b1;
                    end
                end
                default: ;
            endcase
            if (body_end) begin
                if (kind_next != KIND_SKIP) begin
                    w_start = 1'b1;
                    eofp_next = s_end_of_file;
                    phase_next = PH_PARSE;
                end else begin
                    phase_next = PH_M0;
                end
            end
            if (load_out) begin
                phase_next = PH_DONE;
            end
            if (s_end_of_file && phase_next != PH_PARSE) begin
                if (!load_out && phase_reg != PH_DONE) begin
                    load_out = 1'b1;
                    st_new = ST_EARLY_END;
                end
                clr = 1'b1;
                phase_next = PH_SOI0;
                kind_next = KIND_SKIP;
            end
        end else if (phase_reg == PH_PARSE && w_res.done) begin
            if (w_res.err) begin
                load_out = 1'b1;
                st_new = ST_MALFORMED;
                phase_next = PH_DONE;
            end else if (eofp_reg) begin
                load_out = 1'b1;
                st_new = ST_EARLY_END;
            end else begin
                phase_next = PH_M0;
            end
            if (eofp_reg) begin
                clr = 1'b1;
                phase_next = PH_SOI0;
                kind_next = KIND_SKIP;
            end
        end
    end

    assign seg_n = ({1'b0, len_next} > 17'(SEGMENT_BYTES)) ? 17'(SEGMENT_BYTES)
                                                            : {1'b0, len_next};

    jehp_ram #(.DEPTH(SEGMENT_BYTES), .WIDTH(8)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[SEG_AW-1:0]),
        .wr_data (s_data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    jehp_walker u_walker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .clr             (clr),
        .start           (w_start),
        .kind            (kind_next),
        .seg_len         (seg_n),
        .want_thumb      (want_thumb_reg),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .res             (w_res),
        .width_out       (w_w),
        .height_out      (w_h),
        .orient_out      (w_or),
        .thumb_valid_out (w_tv),
        .thumb_off_out   (w_to),
        .thumb_size_out  (w_ts)
    );

    assign m_valid = m_valid_reg;
    assign m_status = st_reg;
    assign m_image_width = w_o_reg;
    assign m_image_height = h_o_reg;
    assign m_orientation = or_o_reg;
    assign m_thumb_valid = tv_o_reg;
    assign m_thumb_offset = to_o_reg;
    assign m_thumb_size = ts_o_reg;

    `JEHP_ASSERT_NOW(a_no_xfer_in_parse, phase_reg == PH_PARSE, !s_ready, "input during walk")
    `JEHP_ASSERT_NOW(a_done_in_parse, w_res.done, phase_reg == PH_PARSE, "walk done outside parse")
    `JEHP_ASSERT_NOW(a_slot_free, load_out, !m_valid_reg || m_ready, "result slot busy")
    `JEHP_ASSERT_NEXT(a_start_leaves, w_start, phase_reg == PH_PARSE, "walk start lost")

endmodule
`default_nettype wire
